### hdl/fue_pkg.sv
// shared types and constants for the frame unescape and checksum block
package fue_pkg;

  localparam int unsigned COUNT_W              = 11;
  localparam int unsigned MAX_BUFFER_BYTES_DEF = 2048;
  localparam int unsigned QUEUE_DEPTH          = 4;
  localparam int unsigned IN_TDATA_W           = 8;
  localparam int unsigned OUT_TDATA_W          = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] MIN_RAW_RESET = COUNT_W'(15);

  localparam logic [7:0] FLAG_BYTE    = 8'h7e;
  localparam logic [7:0] ESC_BYTE     = 8'h7d;
  localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
  localparam logic [7:0] ESC_FOR_ESC  = 8'h01;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_ESCAPE   = 2'd2,
    ST_CHECKSUM = 2'd3
  } frame_status_t;

  // one classified raw byte, handed from front to back
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       last;
    logic       err;
  } fue_item_t;

endpackage

### hdl/fue_front.sv
// front end: escape decoding of raw bytes into classified words
module fue_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              push_valid,
  input  logic              push_ready,
  output fue_pkg::fue_item_t push_item
);
  import fue_pkg::*;

  logic esc_r, esc_nxt;
  logic err_r, err_nxt;
  fue_item_t item;

  always_comb begin
    logic esc_now;
    logic err_now;
    esc_now = esc_r;
    err_now = err_r;
    item    = '0;
    if (!err_r) begin
      priority if (esc_r) begin
        esc_now = 1'b0;
        priority if (in_byte == ESC_FOR_FLAG) begin
          item.emit = 1'b1;
          item.data = FLAG_BYTE;
        end else if (in_byte == ESC_FOR_ESC) begin
          item.emit = 1'b1;
          item.data = ESC_BYTE;
        end else begin
          err_now = 1'b1;
        end
      end else if (in_byte == FLAG_BYTE) begin
        // flag dropped
      end else if (in_byte == ESC_BYTE) begin
        esc_now = 1'b1;
      end else begin
        item.emit = 1'b1;
        item.data = in_byte;
      end
    end
    // escape left open at the end of the buffer
    if (in_last && esc_now && !err_now) begin
      esc_now = 1'b0;
      err_now = 1'b1;
    end
    item.last = in_last;
    item.err  = err_now;
    esc_nxt   = in_last ? 1'b0 : esc_now;
    err_nxt   = in_last ? 1'b0 : err_now;
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
      err_r <= 1'b0;
    end else if (in_valid && push_ready) begin
      esc_r <= esc_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

### hdl/fue_queue.sv
// short register queue between front and back
module fue_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  fue_pkg::fue_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output fue_pkg::fue_item_t pop_item
);
  import fue_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  fue_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/fue_back.sv
// back end: checksum, counts, status and the output register
module fue_back #(
  parameter int unsigned MAX_BUFFER_BYTES = fue_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  fue_pkg::fue_item_t              pop_item,
  input  logic [fue_pkg::COUNT_W-1:0]     min_raw_length,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fue_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import fue_pkg::*;

  localparam int unsigned CAP_INT =
    ((MAX_BUFFER_BYTES - 1) < 32'(COUNT_MAX)) ? (MAX_BUFFER_BYTES - 1) : 32'(COUNT_MAX);
  localparam logic [COUNT_W-1:0] LEN_CAP = COUNT_W'(CAP_INT);
  localparam int unsigned PAD_W = OUT_TDATA_W - 8 - 2 - COUNT_W;

  logic [7:0]         xor_r, xor_nxt;
  logic [COUNT_W-1:0] raw_cnt_r, raw_cnt_nxt;
  logic [COUNT_W-1:0] len_r, len_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_user_r;
  logic                   out_last_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic               produce, out_free, take;
  logic [7:0]         xor_new;
  logic [COUNT_W-1:0] raw_new, len_new;
  frame_status_t      status;

  assign produce   = pop_item.emit || pop_item.last;
  assign out_free  = !out_valid_r || out_tready;
  assign pop_ready = !produce || out_free;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    raw_new = (raw_cnt_r != COUNT_MAX) ? raw_cnt_r + COUNT_W'(1) : raw_cnt_r;
    xor_new = pop_item.emit ? (xor_r ^ pop_item.data) : xor_r;
    len_new = (pop_item.emit && len_r < LEN_CAP) ? len_r + COUNT_W'(1) : len_r;

    status = ST_OK;
    if (pop_item.last) begin
      priority if (raw_new < min_raw_length) begin
        status = ST_SHORT;
      end else if (pop_item.err) begin
        status = ST_ESCAPE;
      end else if (xor_new != 8'h00) begin
        status = ST_CHECKSUM;
      end else begin
        status = ST_OK;
      end
    end

    // state clears after the last byte of a buffer
    raw_cnt_nxt = pop_item.last ? '0 : raw_new;
    xor_nxt     = pop_item.last ? '0 : xor_new;
    len_nxt     = pop_item.last ? '0 : len_new;

    out_valid_nxt = out_valid_r && !out_tready;
    if (take && produce) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r       <= '0;
      raw_cnt_r   <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        xor_r     <= xor_nxt;
        raw_cnt_r <= raw_cnt_nxt;
        len_r     <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && produce) begin
      out_user_r <= pop_item.emit;
      out_last_r <= pop_item.last;
      out_data_r <= {{PAD_W{1'b0}}, len_new, status, pop_item.data};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/frame_unescape_xor_check_core.sv
// top level of the receive-side frame unescape and checksum block
// Takes one raw byte per cycle unless the output stalls, for any mix of flags and escapes.
// A byte is decoded in the front end (an escape bit and an error bit), held in a four-word
// queue and then folded into the checksum and counts by the back end, whose single
// output register gives the result; a byte that yields a result passes the queue
// register and then the output register before it shows on the output.
// Flags and opening escapes give no result.
// The last byte of a buffer always yields a result with frame status and length;
// after an invalid escape no further data bytes appear until the buffer ends.
// min_raw_length may be written only while no buffer byte is in flight.
module frame_unescape_xor_check_core #(
  parameter int unsigned MAX_BUFFER_BYTES = fue_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fue_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] raw_byte
  input  logic                            in_tlast,   // buffer_last
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fue_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] data_byte, [9:8] frame_status,
                                                      // [20:10] frame_length, [23:21] zero
  output logic                            out_tuser,  // [0] data_valid
  output logic                            out_tlast,  // frame_end
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fue_pkg::COUNT_W-1:0]     cfg_data    // min_raw_length
);
  import fue_pkg::*;

  logic [COUNT_W-1:0] min_raw_r;

  logic      push_valid, push_ready;
  fue_item_t push_item;
  logic      pop_valid, pop_ready;
  fue_item_t pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_raw_r <= MIN_RAW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_raw_r <= cfg_data;
    end
  end

  fue_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata[7:0]),
    .in_last    (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  fue_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  fue_back #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .min_raw_length (min_raw_r),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast)
  );

  // a word that does not end a buffer must carry data
  a_mid_word_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser)
    else $error("result without data or frame end");

  // data byte reads zero when no data is carried
  a_empty_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'h00)
    else $error("data byte nonzero without data");

  // status only reported on the frame end
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[9:8] == ST_OK)
    else $error("status set away from frame end");

  // length counts the byte it comes with
  a_length_counts_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[20:10] != '0)
    else $error("zero length with a data byte");

endmodule
